>>> src/multichannel_cosine_nco_assert.svh
// Assertion macros shared by the checker of the multichannel cosine NCO.
// No dependencies; included by name from the files that assert.
`ifndef MULTICHANNEL_COSINE_NCO_ASSERT_SVH
`define MULTICHANNEL_COSINE_NCO_ASSERT_SVH

// Same-cycle implication, reset-qualified
`define NCO_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, reset-qualified
`define NCO_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> src/mcnco_pkg.sv
// Shared types, register map and cosine table builder for the cosine NCO.
// No dependencies; imported by every module of the block.
package mcnco_pkg;

   // Port widths
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 24;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam int CHAN_CMD_W = 4;    // holds any channel index up to 16 channels
   localparam int STEP_WIDE_W = 48;  // widest accumulator supported

   // Register map (word index = paddr[3:2])
   localparam logic [1:0] REG_BASE_INC   = 2'd0;
   localparam logic [1:0] REG_AMPLITUDE  = 2'd1;
   localparam logic [1:0] REG_CHAN_COUNT = 2'd2;

   // Register reset values
   localparam logic [31:0] BASE_INC_RESET   = 32'd39370534;
   localparam logic [14:0] AMPLITUDE_RESET  = 15'd30000;
   localparam logic [3:0]  CHAN_COUNT_RESET = 4'd2;

   // (pi/2)^2 in Q30
   localparam logic [63:0] HALF_PI_SQ_Q30 = 64'd2649351758;
   localparam logic [63:0] ONE_Q30        = 64'd1 << 30;

   typedef struct packed {
      logic [31:0] base_increment;
      logic [14:0] amplitude;
      logic [3:0]  channel_count;
   } cfg_type;

   // Controller to datapath: one channel sample to start
   typedef struct packed {
      logic                  issue;
      logic                  first;
      logic [CHAN_CMD_W-1:0] chan;
      logic                  last;
      logic                  chunk_done;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic advance;
   } stat_type;

   // Quarter-wave cosine entry k in Q15, evaluated at elaboration.
   // Nested Taylor form in Q30 with truncated products, sums clamped at zero.
   function automatic logic [15:0] cos_entry(int unsigned k, int unsigned table_bits);
      logic [63:0] t;
      logic [63:0] u;
      logic [63:0] x;
      logic [63:0] r;
      logic [63:0] q;
      logic [63:0] term;
      logic [63:0] rounded;
      t = 64'(k) << (32 - table_bits);
      u = (t * t) >> 30;
      x = (HALF_PI_SQ_Q30 * u) >> 30;
      r = ONE_Q30;
      for (int n = 7; n >= 1; n--) begin
         unique case (n)
            7:       q = x / 64'd182;
            6:       q = x / 64'd132;
            5:       q = x / 64'd90;
            4:       q = x / 64'd56;
            3:       q = x / 64'd30;
            2:       q = x / 64'd12;
            default: q = x / 64'd2;
         endcase
         term = (q * r) >> 30;
         r = (term >= ONE_Q30) ? 64'd0 : ONE_Q30 - term;
      end
      rounded = (r + (64'd1 << 14)) >> 15;
      return rounded[15:0];
   endfunction

endpackage

>>> src/multichannel_cosine_nco.sv
// Top level of the multichannel cosine NCO.
// Depends on mcnco_pkg, mcnco_csr, mcnco_ctrl and mcnco_dp.
//
//   channel  direction  word contents
//   req_     in         tdata[0] chunk_end (one frame request)
//   rsp_     out        tdata[2:0] channel, [18:3] sample; tlast frame_end;
//                       tuser chunk_done (one word per channel)
//   csr_     in/out     base_increment @0x0, amplitude @0x4, channel_count @0x8
//
// The controller issues one channel a cycle while the output word is not held, and
// the next request is taken on the cycle its last channel issues.
// A request with zero channels is taken and yields no word.
// A sample passes through the table, multiply and output registers after its channel issues.
// Synchronous active-high reset clears phases, control and pipeline valids, and loads the CSRs with reset values.
// A held output word stalls the whole datapath and the sequencer.
module multichannel_cosine_nco #(
   parameter int MAX_CHANNELS = 8,
   parameter int PHASE_BITS   = 32,
   parameter int TABLE_BITS   = 10
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [mcnco_pkg::REQ_DATA_W-1:0] req_tdata,   // [0] chunk_end
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [mcnco_pkg::RSP_DATA_W-1:0] rsp_tdata,   // [2:0] channel, [18:3] sample
   output logic                             rsp_tlast,
   output logic                             rsp_tuser,   // [0] chunk_done
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [mcnco_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [mcnco_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [mcnco_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                             csr_pready
);
   import mcnco_pkg::*;

   cfg_type     cfg;
   cmd_type     cmd;
   stat_type    stat;
   logic [2:0]  out_channel;
   logic [15:0] out_sample;

   mcnco_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   mcnco_ctrl #(
      .MAX_CHANNELS (MAX_CHANNELS)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_chunk_end (req_tdata[0]),
      .channel_count (cfg.channel_count),
      .stat          (stat),
      .cmd           (cmd)
   );

   mcnco_dp #(
      .MAX_CHANNELS (MAX_CHANNELS),
      .PHASE_BITS   (PHASE_BITS),
      .TABLE_BITS   (TABLE_BITS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .cmd            (cmd),
      .stat           (stat),
      .out_valid      (rsp_tvalid),
      .out_ready      (rsp_tready),
      .out_channel    (out_channel),
      .out_sample     (out_sample),
      .out_frame_end  (rsp_tlast),
      .out_chunk_done (rsp_tuser)
   );

   assign rsp_tdata = {5'd0, out_sample, out_channel};

endmodule

>>> src/mcnco_csr.sv
// Configuration register file of the cosine NCO on an APB-style port.
// Depends on mcnco_pkg for the register map and reset values.
module mcnco_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [mcnco_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [mcnco_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [mcnco_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready,
   output mcnco_pkg::cfg_type              cfg
);
   import mcnco_pkg::*;

   logic [31:0] base_inc_ff,   base_inc_in;
   logic [14:0] amplitude_ff,  amplitude_in;
   logic [3:0]  chan_count_ff, chan_count_in;
   logic        wr_en;
   logic [1:0]  reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign reg_idx    = csr_paddr[3:2];

   // Write decode
   always_comb begin
      base_inc_in   = base_inc_ff;
      amplitude_in  = amplitude_ff;
      chan_count_in = chan_count_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_BASE_INC:   base_inc_in   = csr_pwdata;
            REG_AMPLITUDE:  amplitude_in  = csr_pwdata[14:0];
            REG_CHAN_COUNT: chan_count_in = csr_pwdata[3:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_inc_ff   <= BASE_INC_RESET;
         amplitude_ff  <= AMPLITUDE_RESET;
         chan_count_ff <= CHAN_COUNT_RESET;
      end else begin
         base_inc_ff   <= base_inc_in;
         amplitude_ff  <= amplitude_in;
         chan_count_ff <= chan_count_in;
      end
   end

   // Read mux
   always_comb begin
      unique case (reg_idx)
         REG_BASE_INC:   csr_prdata = base_inc_ff;
         REG_AMPLITUDE:  csr_prdata = 32'(amplitude_ff);
         REG_CHAN_COUNT: csr_prdata = 32'(chan_count_ff);
         default:        csr_prdata = '0;
      endcase
   end

   assign cfg.base_increment = base_inc_ff;
   assign cfg.amplitude      = amplitude_ff;
   assign cfg.channel_count  = chan_count_ff;

endmodule

>>> src/mcnco_ctrl.sv
// Frame sequencer of the cosine NCO: takes frame requests, walks the channels.
// Depends on mcnco_pkg for the command and status structs.
module mcnco_ctrl #(
   parameter int MAX_CHANNELS = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic                  req_chunk_end,
   input  logic [3:0]            channel_count,
   input  mcnco_pkg::stat_type   stat,
   output mcnco_pkg::cmd_type    cmd
);
   import mcnco_pkg::*;

   localparam int CH_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int CNT_W = $clog2(MAX_CHANNELS + 1);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_RUN  = 2'b10
   } state_type;

   state_type        state_ff,  state_in;
   logic [CH_W-1:0]  chan_ff,   chan_in;
   logic [CNT_W-1:0] count_ff,  count_in;
   logic             chunk_ff,  chunk_in;
   logic [CNT_W-1:0] sat_count;
   logic             is_last;
   logic             issue;
   logic             accept;

   // Channel count clipped to the number of accumulators
   assign sat_count = ({1'b0, channel_count} > 5'(MAX_CHANNELS)) ?
                      CNT_W'(MAX_CHANNELS) : CNT_W'(channel_count);

   assign is_last    = (CNT_W'(chan_ff) + CNT_W'(1)) == count_ff;
   assign issue      = (state_ff == ST_RUN) && stat.advance;
   assign req_tready = (state_ff == ST_IDLE) || (issue && is_last);
   assign accept     = req_tvalid && req_tready;

   // Next state
   always_comb begin
      state_in = state_ff;
      chan_in  = chan_ff;
      count_in = count_ff;
      chunk_in = chunk_ff;
      if (issue) begin
         chan_in = chan_ff + CH_W'(1);
         if (is_last)
            state_in = ST_IDLE;
      end
      // a new frame may load on the cycle the last channel issues
      if (accept) begin
         chan_in  = '0;
         count_in = sat_count;
         chunk_in = req_chunk_end;
         state_in = (sat_count != '0) ? ST_RUN : ST_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         chan_ff  <= '0;
         count_ff <= '0;
         chunk_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         chan_ff  <= chan_in;
         count_ff <= count_in;
         chunk_ff <= chunk_in;
      end
   end

   assign cmd.issue      = issue;
   assign cmd.first      = (chan_ff == '0);
   assign cmd.chan       = CHAN_CMD_W'(chan_ff);
   assign cmd.last       = is_last;
   assign cmd.chunk_done = is_last && chunk_ff;

endmodule

>>> src/mcnco_dp.sv
// Datapath of the cosine NCO: phase accumulators, quarter-wave table,
// amplitude multiply and output register. Depends on mcnco_pkg.
module mcnco_dp #(
   parameter int MAX_CHANNELS = 8,
   parameter int PHASE_BITS   = 32,
   parameter int TABLE_BITS   = 10
) (
   input  logic                clock,
   input  logic                reset,
   input  mcnco_pkg::cfg_type  cfg,
   input  mcnco_pkg::cmd_type  cmd,
   output mcnco_pkg::stat_type stat,
   output logic                out_valid,
   input  logic                out_ready,
   output logic [2:0]          out_channel,
   output logic [15:0]         out_sample,
   output logic                out_frame_end,
   output logic                out_chunk_done
);
   import mcnco_pkg::*;

   localparam int CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int Q    = 1 << (TABLE_BITS - 2);
   localparam int AW   = TABLE_BITS - 1;
   localparam int UP   = (PHASE_BITS >= 32) ? PHASE_BITS - 32 : 0;
   localparam int DOWN = (PHASE_BITS < 32) ? 32 - PHASE_BITS : 0;

   // Quarter-wave cosine table, Q15, entries 0..Q
   logic [15:0] cos_rom [Q+1];
   for (genvar k = 0; k <= Q; k++) begin : g_rom
      localparam logic [15:0] ENTRY = cos_entry(k, TABLE_BITS);
      assign cos_rom[k] = ENTRY;
   end

   logic [PHASE_BITS-1:0] phase_ff [MAX_CHANNELS];
   logic [PHASE_BITS-1:0] phase_in;
   logic [PHASE_BITS-1:0] inc_ff, inc_in;
   logic [PHASE_BITS-1:0] inc_base;
   logic [PHASE_BITS-1:0] step;
   logic [STEP_WIDE_W-1:0] step_wide;
   logic [CH_W-1:0]       ch;
   logic [PHASE_BITS-1:0] cur_phase;
   logic [TABLE_BITS-1:0] tidx;
   logic [1:0]            quad;
   logic [AW-2:0]         off;
   logic [AW-1:0]         rom_addr;
   logic                  adv;

   // stage 1: table word
   logic        s1_valid_ff;
   logic [15:0] s1_mag_ff;
   logic        s1_neg_ff;
   logic [2:0]  s1_chan_ff;
   logic        s1_last_ff;
   logic        s1_done_ff;
   // stage 2: scaled product
   logic        s2_valid_ff;
   logic [30:0] s2_prod_ff;
   logic        s2_neg_ff;
   logic [2:0]  s2_chan_ff;
   logic        s2_last_ff;
   logic        s2_done_ff;
   // stage 3: output word
   logic        s3_valid_ff;
   logic [15:0] s3_sample_ff;
   logic [2:0]  s3_chan_ff;
   logic        s3_last_ff;
   logic        s3_done_ff;
   logic [15:0] s2_mag;

   // whole pipeline moves together unless the output word is held
   assign adv          = !s3_valid_ff || out_ready;
   assign stat.advance = adv;

   // Phase step scaled to accumulator width
   assign step_wide = (STEP_WIDE_W'(cfg.base_increment) << UP) >> DOWN;
   assign step      = step_wide[PHASE_BITS-1:0];

   // Channel j advances by step*j: a running multiple restarted at channel 0
   assign ch        = cmd.chan[CH_W-1:0];
   assign cur_phase = phase_ff[ch];
   assign inc_base  = cmd.first ? '0 : inc_ff;
   assign phase_in  = cur_phase + inc_base;
   assign inc_in    = inc_base + step;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_CHANNELS; i++)
            phase_ff[i] <= '0;
      end else if (cmd.issue) begin
         phase_ff[ch] <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.issue)
         inc_ff <= inc_in;
   end

   // Table lookup with quadrant folding
   assign tidx     = cur_phase[PHASE_BITS-1 -: TABLE_BITS];
   assign quad     = tidx[TABLE_BITS-1 -: 2];
   assign off      = tidx[TABLE_BITS-3:0];
   assign rom_addr = quad[0] ? (AW'(Q) - {1'b0, off}) : {1'b0, off};

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= cmd.issue;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   assign s2_mag = s2_prod_ff[30:15];

   // Payload pipeline
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_mag_ff    <= cos_rom[rom_addr];
         s1_neg_ff    <= quad[0] ^ quad[1];
         s1_chan_ff   <= cmd.chan[2:0];
         s1_last_ff   <= cmd.last;
         s1_done_ff   <= cmd.chunk_done;

         s2_prod_ff   <= 31'(s1_mag_ff) * 31'(cfg.amplitude);
         s2_neg_ff    <= s1_neg_ff;
         s2_chan_ff   <= s1_chan_ff;
         s2_last_ff   <= s1_last_ff;
         s2_done_ff   <= s1_done_ff;

         s3_sample_ff <= s2_neg_ff ? (16'd0 - s2_mag) : s2_mag;
         s3_chan_ff   <= s2_chan_ff;
         s3_last_ff   <= s2_last_ff;
         s3_done_ff   <= s2_done_ff;
      end
   end

   assign out_valid      = s3_valid_ff;
   assign out_channel    = s3_chan_ff;
   assign out_sample     = s3_sample_ff;
   assign out_frame_end  = s3_last_ff;
   assign out_chunk_done = s3_done_ff;

endmodule

>>> src/mcnco_checker.sv
// Port-level checker for the multichannel cosine NCO, bound to the top level.
// Depends on mcnco_pkg and the assertion macros header.
`include "multichannel_cosine_nco_assert.svh"

module mcnco_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [mcnco_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                             rsp_tlast,
   input logic                             rsp_tuser
);
   import mcnco_pkg::*;

   // held output word keeps its contents
   `NCO_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast) && $stable(rsp_tuser), "rsp word changed while stalled")

   // chunk end is flagged only on a frame's last word
   `NCO_ASSERT_IMPL(a_chunk_on_last, clock, reset, rsp_tvalid && rsp_tuser, rsp_tlast, "chunk_done without frame_end")

   // within a frame the channels follow back to back in order
   `NCO_ASSERT_NEXT(a_chan_seq, clock, reset, rsp_tvalid && rsp_tready && !rsp_tlast, rsp_tvalid && (rsp_tdata[2:0] == 3'($past(rsp_tdata[2:0]) + 3'd1)), "frame channel sequence broken")

   // right after reset: no word out, request side ready
   `NCO_ASSERT_IMPL(a_reset_empty, clock, reset, $past(reset), !rsp_tvalid && req_tready, "bad state after reset")

endmodule

bind multichannel_cosine_nco mcnco_checker u_mcnco_checker (.*);
